// ----- design/cnmal_pkg.sv -----
`default_nettype none

package cnmal_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned TableAddrW = $clog2(TableDepth);
  localparam int unsigned ActW       = 8;
  localparam int unsigned PixelW     = 8;
  localparam int unsigned WeightW    = 16;
  localparam int unsigned BiasW      = 16;
  localparam int unsigned ProdW      = PixelW + 1 + WeightW;
  localparam int unsigned AccW       = 32;
  localparam int unsigned BiasShW    = 4;
  localparam int unsigned OutShW     = 5;
  localparam int unsigned SatBaseW   = 10;
  localparam int unsigned BoundW     = SatBaseW + (1 << OutShW) + 1;
  localparam int unsigned ClipW      = 2;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 5;

  localparam logic signed [BoundW-1:0]  SatBase      = BoundW'(512);
  localparam logic [TableAddrW-1:0]     IdxSatHigh   = TableAddrW'(10'h1FF);
  localparam logic [TableAddrW-1:0]     IdxSatLow    = TableAddrW'(10'h200);
  localparam logic [BiasShW-1:0]        BiasShiftRst = BiasShW'(8);
  localparam logic [OutShW-1:0]         OutShiftRst  = OutShW'(10);

  typedef enum logic [0:0] {
    OpTerm    = 1'b0,
    OpTableWr = 1'b1
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBiasShift = 1'b0,
    CfgOutShift  = 1'b1
  } cfg_reg_e;

  typedef enum logic [ClipW-1:0] {
    ClipNone = 2'd0,
    ClipHigh = 2'd1,
    ClipLow  = 2'd2
  } clip_e;

endpackage

`default_nettype wire

// ----- design/conv_neuron_mac_activation_lut.sv -----
`default_nettype none

// CNN neuron engine: takes one item per clock while the input is not stalled
// (a multiply-accumulate term or an activation table write) and emits one
// result per term marked last. A term passes the input register, 8x16
// multiply, 32-bit accumulate, then saturate/scale and the registered read of
// the 1024x8 activation table RAM, whose output register is the result stage.
// Stall ripples back only through full stages, so up to four items are held
// while a result waits. Table writes and terms not marked last give no result.
// Configuration is always ready; write it only while the block is idle.
module conv_neuron_mac_activation_lut_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,

  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [cnmal_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [cnmal_pkg::CfgDataW-1:0]        cfg_data_i,

  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic                                  opcode_i,
  input  wire logic [cnmal_pkg::PixelW-1:0]          pixel_i,
  input  wire logic signed [cnmal_pkg::WeightW-1:0]  weight_i,
  input  wire logic signed [cnmal_pkg::BiasW-1:0]    bias_i,
  input  wire logic                                  first_term_i,
  input  wire logic                                  last_term_i,
  input  wire logic [cnmal_pkg::TableAddrW-1:0]      table_addr_i,
  input  wire logic [cnmal_pkg::ActW-1:0]            table_data_i,

  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [cnmal_pkg::ActW-1:0]                 activation_o,
  output logic [cnmal_pkg::TableAddrW-1:0]           table_index_o,
  output logic [cnmal_pkg::ClipW-1:0]                clip_status_o
);

  logic [cnmal_pkg::BiasShW-1:0] bias_shift_q;
  logic [cnmal_pkg::OutShW-1:0]  out_shift_q;

  logic v1_q, v2_q, v3_q, v4_q;
  logic e1, e2, e3, e4;

  logic                                  op1_q;
  logic [cnmal_pkg::PixelW-1:0]          pixel1_q;
  logic signed [cnmal_pkg::WeightW-1:0]  weight1_q;
  logic signed [cnmal_pkg::BiasW-1:0]    bias1_q;
  logic                                  first1_q, last1_q;
  logic [cnmal_pkg::TableAddrW-1:0]      addr1_q;
  logic [cnmal_pkg::ActW-1:0]            data1_q;

  logic                                  op2_q;
  logic signed [cnmal_pkg::ProdW-1:0]    prod2_q;
  logic signed [cnmal_pkg::ProdW-1:0]    prod2_d;
  logic signed [cnmal_pkg::BiasW-1:0]    bias2_q;
  logic                                  first2_q, last2_q;
  logic [cnmal_pkg::TableAddrW-1:0]      addr2_q;
  logic [cnmal_pkg::ActW-1:0]            data2_q;

  logic [cnmal_pkg::AccW-1:0]            acc_q, acc_d;
  logic [cnmal_pkg::AccW-1:0]            bias_wide, bias_base, prod_wide;

  logic                                  op3_q, last3_q;
  logic signed [cnmal_pkg::AccW-1:0]     sum3_q;
  logic [cnmal_pkg::TableAddrW-1:0]      addr3_q;
  logic [cnmal_pkg::ActW-1:0]            data3_q;

  logic signed [cnmal_pkg::BoundW-1:0]   sum_ext, bound;
  logic signed [cnmal_pkg::AccW-1:0]     sum_shifted;
  logic                                  sat_hi, sat_lo;
  logic [cnmal_pkg::TableAddrW-1:0]      idx_d, idx4_q;
  logic [cnmal_pkg::ClipW-1:0]           clip_d, clip4_q;
  logic                                  tbl_wr, result3;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_shift_q <= cnmal_pkg::BiasShiftRst;
      out_shift_q  <= cnmal_pkg::OutShiftRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cnmal_pkg::cfg_reg_e'(cfg_index_i))
        cnmal_pkg::CfgBiasShift: bias_shift_q <= cfg_data_i[cnmal_pkg::BiasShW-1:0];
        cnmal_pkg::CfgOutShift:  out_shift_q  <= cfg_data_i[cnmal_pkg::OutShW-1:0];
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or its successor advances
  assign e4 = !v4_q || !out_stall_i;
  assign e3 = !v3_q || e4;
  assign e2 = !v2_q || e3;
  assign e1 = !v1_q || e2;
  assign in_stall_o = !e1;

  assign prod2_d   = $signed({1'b0, pixel1_q}) * weight1_q;
  assign bias_wide = {{(cnmal_pkg::AccW - cnmal_pkg::BiasW){bias2_q[cnmal_pkg::BiasW-1]}},
                      bias2_q};
  assign bias_base = bias_wide << bias_shift_q;
  assign prod_wide = {{(cnmal_pkg::AccW - cnmal_pkg::ProdW){prod2_q[cnmal_pkg::ProdW-1]}},
                      prod2_q};
  assign acc_d     = (first2_q ? bias_base : acc_q) + prod_wide;

  assign sum_ext     = {{(cnmal_pkg::BoundW - cnmal_pkg::AccW){sum3_q[cnmal_pkg::AccW-1]}},
                        sum3_q};
  assign bound       = cnmal_pkg::SatBase << out_shift_q;
  assign sat_hi      = sum_ext >= bound;
  assign sat_lo      = sum_ext < -bound;
  assign sum_shifted = sum3_q >>> out_shift_q;

  always_comb begin
    if (sat_hi) begin
      idx_d  = cnmal_pkg::IdxSatHigh;
      clip_d = cnmal_pkg::ClipHigh;
    end else if (sat_lo) begin
      idx_d  = cnmal_pkg::IdxSatLow;
      clip_d = cnmal_pkg::ClipLow;
    end else begin
      idx_d  = sum_shifted[cnmal_pkg::TableAddrW-1:0];
      clip_d = cnmal_pkg::ClipNone;
    end
  end

  assign tbl_wr  = v3_q && e4 && (op3_q == cnmal_pkg::OpTableWr);
  assign result3 = v3_q && (op3_q == cnmal_pkg::OpTerm) && last3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      if (e1) v1_q <= in_valid_i;
      if (e2) v2_q <= v1_q;
      if (e3) v3_q <= v2_q;
      if (e4) v4_q <= result3;
      if (v2_q && e3 && (op2_q == cnmal_pkg::OpTerm)) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (e1) begin
      op1_q     <= opcode_i;
      pixel1_q  <= pixel_i;
      weight1_q <= weight_i;
      bias1_q   <= bias_i;
      first1_q  <= first_term_i;
      last1_q   <= last_term_i;
      addr1_q   <= table_addr_i;
      data1_q   <= table_data_i;
    end
    if (e2) begin
      op2_q    <= op1_q;
      prod2_q  <= prod2_d;
      bias2_q  <= bias1_q;
      first2_q <= first1_q;
      last2_q  <= last1_q;
      addr2_q  <= addr1_q;
      data2_q  <= data1_q;
    end
    if (e3) begin
      op3_q   <= op2_q;
      sum3_q  <= acc_d;
      last3_q <= last2_q;
      addr3_q <= addr2_q;
      data3_q <= data2_q;
    end
    if (e4) begin
      idx4_q  <= idx_d;
      clip4_q <= clip_d;
    end
  end

  cnmal_ram #(
    .Width (cnmal_pkg::ActW),
    .Depth (cnmal_pkg::TableDepth)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (tbl_wr),
    .wr_addr_i (addr3_q),
    .wr_data_i (data3_q),
    .rd_en_i   (e4),
    .rd_addr_i (idx_d),
    .rd_data_o (activation_o)
  );

  assign out_valid_o   = v4_q;
  assign table_index_o = idx4_q;
  assign clip_status_o = clip4_q;

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("input stalled with an empty stage");

  a_no_result_from_non_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && e4 && !result3) |=> !out_valid_o)
    else $error("result from a table write or non-last term");

  a_table_write_keeps_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && e3 && (op2_q == cnmal_pkg::OpTableWr)) |=> $stable(acc_q))
    else $error("table write changed the accumulator");

  a_clip_index_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (clip_status_o == cnmal_pkg::ClipHigh)) |->
      (table_index_o == cnmal_pkg::IdxSatHigh))
    else $error("saturated high with wrong index");

  a_clip_low_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (clip_status_o == cnmal_pkg::ClipLow)) |->
      (table_index_o == cnmal_pkg::IdxSatLow))
    else $error("saturated low with wrong index");
`endif

endmodule

`default_nettype wire

// ----- design/cnmal_ram.sv -----
`default_nettype none

module cnmal_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_conv_neuron_mac_activation_lut_core.sv -----
`timescale 1ns / 1ps

module tb_conv_neuron_mac_activation_lut_core;

  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned RxHoldLen     = 80;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseItems    = 240;

  typedef struct {
    cnmal_pkg::opcode_e                   op;
    logic [cnmal_pkg::PixelW-1:0]         pixel;
    logic signed [cnmal_pkg::WeightW-1:0] weight;
    logic signed [cnmal_pkg::BiasW-1:0]   bias;
    logic                                 first;
    logic                                 last;
    logic [cnmal_pkg::TableAddrW-1:0]     addr;
    logic [cnmal_pkg::ActW-1:0]           data;
  } neuron_item_t;

  typedef struct {
    logic [cnmal_pkg::ActW-1:0]       act;
    logic [cnmal_pkg::TableAddrW-1:0] idx;
    cnmal_pkg::clip_e                 clip;
  } activation_t;

  logic                                 clk_i        = 1'b0;
  logic                                 rst_ni       = 1'b0;
  logic                                 cfg_valid_i  = 1'b0;
  logic                                 cfg_ready_o;
  logic [cnmal_pkg::CfgIdxW-1:0]        cfg_index_i  = '0;
  logic [cnmal_pkg::CfgDataW-1:0]       cfg_data_i   = '0;
  logic                                 in_valid_i   = 1'b0;
  logic                                 in_stall_o;
  logic                                 opcode_i     = 1'b0;
  logic [cnmal_pkg::PixelW-1:0]         pixel_i      = '0;
  logic signed [cnmal_pkg::WeightW-1:0] weight_i     = '0;
  logic signed [cnmal_pkg::BiasW-1:0]   bias_i       = '0;
  logic                                 first_term_i = 1'b0;
  logic                                 last_term_i  = 1'b0;
  logic [cnmal_pkg::TableAddrW-1:0]     table_addr_i = '0;
  logic [cnmal_pkg::ActW-1:0]           table_data_i = '0;
  logic                                 out_valid_o;
  logic                                 out_stall_i  = 1'b0;
  logic [cnmal_pkg::ActW-1:0]           activation_o;
  logic [cnmal_pkg::TableAddrW-1:0]     table_index_o;
  logic [cnmal_pkg::ClipW-1:0]          clip_status_o;

  conv_neuron_mac_activation_lut_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .pixel_i       (pixel_i),
    .weight_i      (weight_i),
    .bias_i        (bias_i),
    .first_term_i  (first_term_i),
    .last_term_i   (last_term_i),
    .table_addr_i  (table_addr_i),
    .table_data_i  (table_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .activation_o  (activation_o),
    .table_index_o (table_index_o),
    .clip_status_o (clip_status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [cnmal_pkg::AccW-1:0]    acc_q = '0;
  logic [cnmal_pkg::ActW-1:0]    lut_mem [cnmal_pkg::TableDepth];
  bit                            lut_written [cnmal_pkg::TableDepth];
  logic [cnmal_pkg::BiasShW-1:0] bias_sh = cnmal_pkg::BiasShiftRst;
  logic [cnmal_pkg::OutShW-1:0]  out_sh  = cnmal_pkg::OutShiftRst;
  activation_t                   activations_due [$];
  int unsigned                   fail_count = 0;
  bit                            tx_idle_en = 1'b1;
  bit                            rx_idle_en = 1'b1;
  bit                            rx_hold_req = 1'b0;
  int unsigned                   rx_hold_cnt = 0;
  int unsigned                   quiet_cycles = 0;

  function automatic logic [cnmal_pkg::AccW-1:0] sum_after(neuron_item_t it);
    logic [cnmal_pkg::AccW-1:0] base;
    longint                     prod;
    base = it.first ? (cnmal_pkg::AccW'(it.bias) << bias_sh) : acc_q;
    prod = longint'(it.pixel) * longint'(it.weight);
    return base + cnmal_pkg::AccW'(prod);
  endfunction

  function automatic activation_t grade_sum(logic [cnmal_pkg::AccW-1:0] sum_bits);
    activation_t r;
    longint      s;
    longint      bound;
    s     = longint'($signed(sum_bits));
    bound = longint'(512) << out_sh;
    if (s >= bound) begin
      r.idx  = cnmal_pkg::IdxSatHigh;
      r.clip = cnmal_pkg::ClipHigh;
    end else if (s < -bound) begin
      r.idx  = cnmal_pkg::IdxSatLow;
      r.clip = cnmal_pkg::ClipLow;
    end else begin
      r.idx  = cnmal_pkg::TableAddrW'(s >>> out_sh);
      r.clip = cnmal_pkg::ClipNone;
    end
    r.act = lut_mem[r.idx];
    return r;
  endfunction

  function automatic void absorb_item(neuron_item_t it);
    if (it.op == cnmal_pkg::OpTableWr) begin
      lut_mem[it.addr]     = it.data;
      lut_written[it.addr] = 1'b1;
    end else begin
      acc_q = sum_after(it);
      if (it.last) activations_due.push_back(grade_sum(acc_q));
    end
  endfunction

  function automatic void flag(string what, logic [31:0] want, logic [31:0] got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: expected %0h, got %0h", $realtime, what, want, got);
    end
  endfunction

  function automatic logic signed [cnmal_pkg::WeightW-1:0] rand_coef();
    logic signed [cnmal_pkg::WeightW-1:0] v;
    v = cnmal_pkg::WeightW'($urandom);
    if ($urandom_range(3, 0) != 0) v = v >>> $urandom_range(15, 1);
    return v;
  endfunction

  function automatic neuron_item_t mk_term(logic [cnmal_pkg::PixelW-1:0] pixel,
                                           logic signed [cnmal_pkg::WeightW-1:0] weight,
                                           logic signed [cnmal_pkg::BiasW-1:0] bias,
                                           logic first, logic last);
    neuron_item_t it;
    it.op     = cnmal_pkg::OpTerm;
    it.pixel  = pixel;
    it.weight = weight;
    it.bias   = bias;
    it.first  = first;
    it.last   = last;
    it.addr   = cnmal_pkg::TableAddrW'($urandom);
    it.data   = cnmal_pkg::ActW'($urandom);
    return it;
  endfunction

  function automatic neuron_item_t mk_write(logic [cnmal_pkg::TableAddrW-1:0] addr,
                                            logic [cnmal_pkg::ActW-1:0] data);
    neuron_item_t it;
    it        = mk_term(cnmal_pkg::PixelW'($urandom), cnmal_pkg::WeightW'($urandom),
                        cnmal_pkg::BiasW'($urandom), 1'($urandom), 1'($urandom));
    it.op     = cnmal_pkg::OpTableWr;
    it.addr   = addr;
    it.data   = data;
    return it;
  endfunction

  function automatic neuron_item_t make_term(logic first, logic last);
    logic [cnmal_pkg::PixelW-1:0] pixel;
    pixel = $urandom_range(1, 0) ? cnmal_pkg::PixelW'($urandom)
                                 : cnmal_pkg::PixelW'($urandom_range(15, 0));
    return mk_term(pixel, rand_coef(), rand_coef(), first, last);
  endfunction

  task automatic send_item(neuron_item_t it);
    if (tx_idle_en) begin
      while ($urandom_range(99, 0) < 34) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= it.op;
    pixel_i      <= it.pixel;
    weight_i     <= it.weight;
    bias_i       <= it.bias;
    first_term_i <= it.first;
    last_term_i  <= it.last;
    table_addr_i <= it.addr;
    table_data_i <= it.data;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    absorb_item(it);
  endtask

  // write the entry a finishing term will read first, unless it holds data already
  task automatic issue(neuron_item_t it);
    activation_t peek;
    if (it.op == cnmal_pkg::OpTerm && it.last) begin
      peek = grade_sum(sum_after(it));
      if (!lut_written[peek.idx]) begin
        send_item(mk_write(peek.idx, cnmal_pkg::ActW'($urandom)));
      end
    end
    send_item(it);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (activations_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cnmal_pkg::cfg_reg_e idx, logic [cnmal_pkg::CfgDataW-1:0] val);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == cnmal_pkg::CfgBiasShift) begin
      bias_sh = cnmal_pkg::BiasShW'(val);
    end else begin
      out_sh = val;
    end
  endtask

  task automatic test_edge_cases();
    neuron_item_t wr;
    issue(mk_write('0, '0));
    issue(mk_write('1, '1));
    issue(mk_term('0, '0, '0, 1'b1, 1'b1));
    issue(mk_term(8'd255, 16'sd32767, 16'sd32767, 1'b1, 1'b1));
    issue(mk_term(8'd255, -16'sd32768, -16'sd32768, 1'b1, 1'b1));
    issue(mk_term('0, '0, 16'sd2048, 1'b1, 1'b1));
    issue(mk_term(8'd1, -16'sd1, 16'sd2048, 1'b1, 1'b1));
    issue(mk_term('0, '0, -16'sd2048, 1'b1, 1'b1));
    issue(mk_term(8'd1, -16'sd1, -16'sd2048, 1'b1, 1'b1));
    issue(mk_term(8'd10, 16'sd100, 16'sd5, 1'b1, 1'b0));
    issue(mk_term(8'd20, -16'sd50, '0, 1'b0, 1'b0));
    issue(mk_term(8'd3, 16'sd7, '0, 1'b0, 1'b1));
    issue(mk_term(8'd200, -16'sd300, -16'sd7, 1'b0, 1'b1));
    wr       = mk_write(cnmal_pkg::TableAddrW'($urandom), cnmal_pkg::ActW'($urandom));
    wr.first = 1'b1;
    wr.last  = 1'b1;
    issue(wr);
    issue(mk_term(8'hAA, 16'sh5555, -16'sh5556, 1'b1, 1'b1));
  endtask

  task automatic test_acc_wrap();
    write_reg(cnmal_pkg::CfgBiasShift, 5'd15);
    write_reg(cnmal_pkg::CfgOutShift, 5'd22);
    issue(mk_term(8'd255, 16'sd32767, 16'sd32767, 1'b1, 1'b0));
    for (int k = 0; k < 136; k++) begin
      issue(mk_term(8'd255, 16'sd32767, '0, 1'b0, (k % 16 == 15) || (k == 135)));
    end
  endtask

  task automatic test_output_holdoff();
    tx_idle_en  = 1'b0;
    rx_hold_req <= 1'b1;
    repeat (32) issue(make_term(1'b1, 1'b1));
    rx_hold_req <= 1'b0;
    tx_idle_en  = 1'b1;
    settle();
  endtask

  task automatic run_phase(logic [cnmal_pkg::BiasShW-1:0] bs,
                           logic [cnmal_pkg::OutShW-1:0] os, bit idles);
    int unsigned sent;
    int unsigned roll;
    int unsigned len;
    write_reg(cnmal_pkg::CfgBiasShift, cnmal_pkg::CfgDataW'(bs));
    write_reg(cnmal_pkg::CfgOutShift, os);
    tx_idle_en = idles;
    rx_idle_en <= idles;
    sent = 0;
    while (sent < PhaseItems) begin
      roll = $urandom_range(99, 0);
      if (roll < 8) begin
        issue(mk_write(cnmal_pkg::TableAddrW'($urandom), cnmal_pkg::ActW'($urandom)));
        sent++;
      end else if (roll < 14) begin
        issue(make_term(1'($urandom), 1'($urandom)));
        sent++;
      end else begin
        len = ($urandom_range(9, 0) == 0) ? $urandom_range(48, 1) : $urandom_range(6, 1);
        for (int k = 0; k < len; k++) begin
          issue(make_term(k == 0, k == len - 1));
          sent++;
        end
      end
    end
  endtask

  task automatic test_random_phases();
    run_phase(4'd0, 5'd0, 1'b1);
    run_phase(4'd15, 5'd20, 1'b1);
    run_phase(cnmal_pkg::BiasShiftRst, cnmal_pkg::OutShiftRst, 1'b0);
    run_phase(4'd4, 5'd31, 1'b1);
    repeat (2) begin
      run_phase(cnmal_pkg::BiasShW'($urandom_range(15, 0)),
                cnmal_pkg::OutShW'($urandom_range(31, 0)), 1'b1);
    end
  endtask

  always @(posedge clk_i) begin
    if (rx_hold_req && rx_hold_cnt < RxHoldLen) begin
      out_stall_i <= 1'b1;
      rx_hold_cnt <= rx_hold_cnt + 1;
    end else begin
      out_stall_i <= rx_idle_en && ($urandom_range(99, 0) < 34);
      if (!rx_hold_req) rx_hold_cnt <= 0;
    end
  end

  always @(posedge clk_i) begin
    activation_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (activations_due.size() == 0) begin
        flag("results pending", 1, 0);
      end else begin
        want = activations_due.pop_front();
        if (activation_o !== want.act) flag("activation", want.act, activation_o);
        if (table_index_o !== want.idx) flag("table_index", want.idx, table_index_o);
        if (clip_status_o !== want.clip) flag("clip_status", want.clip, clip_status_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WatchdogLimit);
    $display("conv_neuron_mac_activation_lut_core regression: fail");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_edge_cases();
    test_acc_wrap();
    test_output_holdoff();
    test_random_phases();
    settle();
    if (fail_count == 0) begin
      $display("conv_neuron_mac_activation_lut_core regression: pass");
    end else begin
      $display("conv_neuron_mac_activation_lut_core regression: fail");
    end
    $finish;
  end

endmodule
